// File: rtl/core/modbus_coil_frame_generator_assert.svh
// Assertion macros for the checker file of this block.
`ifndef MODBUS_COIL_FRAME_GENERATOR_ASSERT_SVH
`define MODBUS_COIL_FRAME_GENERATOR_ASSERT_SVH

// Checked on every clock edge while the block is out of reset.
`define MCFG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MCFG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/mcfg_pkg.sv
package mcfg_pkg;

    localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [7:0]  COIL_ON_BYTE    = 8'hFF;
    localparam logic [7:0]  COIL_OFF_BYTE   = 8'h00;
    localparam logic [7:0]  ZERO_BYTE       = 8'h00;
    localparam logic [7:0]  RELAY_FIRST     = 8'd1;
    localparam logic [7:0]  RELAY_LAST      = 8'd4;
    localparam int          RELAY_COUNT     = 4;

    localparam logic OP_ALL_ON = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    // Position of a byte inside one eight-byte frame, in transmit order.
    typedef enum logic [2:0] {
        POS_ADDR,
        POS_FUNC,
        POS_COIL_HI,
        POS_COIL_LO,
        POS_VALUE_HI,
        POS_VALUE_LO,
        POS_CRC_LO,
        POS_CRC_HI
    } t_byte_pos;

    typedef enum logic [2:0] {
        CFG_DEV_ADDR,
        CFG_FIRST_COIL,
        CFG_RELAY_ONE,
        CFG_RELAY_TWO,
        CFG_RELAY_THREE,
        CFG_RELAY_FOUR
    } t_cfg_idx;

    typedef logic [RELAY_COUNT-1:0][1:0] t_relay_map;

    typedef struct packed {
        logic       all_on;
        logic [1:0] target;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [15:0] first_coil;
    } t_frame_cfg;

    // One byte of CRC16/Modbus, reflected, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/core/modbus_coil_frame_generator.sv
// Channel   | Dir | Signals                        | Word contents (lowest bit first)
// s_axis    | in  | tvalid tready tdata tuser      | tdata: relay_choice; tuser: op
// m_axis    | out | tvalid tready tdata tuser tlast| tdata: frame_byte; tuser: frame_end;
//           |     |                                | tlast: last
// cfg       | in  | i_cfg_we i_cfg_idx i_cfg_data  | register index and value, no read-back
//
// A command yields COIL_COUNT frames of eight bytes, one byte per cycle while
// m_axis does not stall. The command word passes a holding register and the
// byte sequencer before its first byte leaves the output register; commands
// follow gap-free, since the next one waits in the holding register while bytes
// go out. Reset is synchronous and active low and clears both valid flags.
// A stall on m_axis freezes the byte sequence; a select of an unknown relay
// is taken and produces no bytes.
module modbus_coil_frame_generator #(
    parameter int COIL_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] relay_choice
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tuser,   // [0] frame_end
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    mcfg_pkg::t_frame_cfg r_cfg;
    mcfg_pkg::t_relay_map r_relay_map;
    logic                 cmd_valid;
    logic                 take;
    mcfg_pkg::t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr   <= 8'd1;
            r_cfg.first_coil <= 16'd0;
            r_relay_map[0]   <= 2'd2;
            r_relay_map[1]   <= 2'd1;
            r_relay_map[2]   <= 2'd0;
            r_relay_map[3]   <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (mcfg_pkg::t_cfg_idx'(i_cfg_idx))
                mcfg_pkg::CFG_DEV_ADDR:    r_cfg.dev_addr   <= i_cfg_data[7:0];
                mcfg_pkg::CFG_FIRST_COIL:  r_cfg.first_coil <= i_cfg_data;
                mcfg_pkg::CFG_RELAY_ONE:   r_relay_map[0]   <= i_cfg_data[1:0];
                mcfg_pkg::CFG_RELAY_TWO:   r_relay_map[1]   <= i_cfg_data[1:0];
                mcfg_pkg::CFG_RELAY_THREE: r_relay_map[2]   <= i_cfg_data[1:0];
                mcfg_pkg::CFG_RELAY_FOUR:  r_relay_map[3]   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    mcfg_cmd u_cmd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .i_relay_map  (r_relay_map),
        .i_take       (take),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    mcfg_frame #(
        .COIL_COUNT(COIL_COUNT)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_take       (take),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

// File: rtl/core/mcfg_cmd.sv
module mcfg_cmd (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] relay_choice
    input  logic                  s_axis_tuser,  // [0] op
    input  mcfg_pkg::t_relay_map  i_relay_map,
    input  logic                  i_take,
    output logic                  o_cmd_valid,
    output mcfg_pkg::t_cmd        o_cmd
);

    logic           r_valid;
    logic           n_valid;
    mcfg_pkg::t_cmd r_cmd;
    mcfg_pkg::t_cmd n_cmd;
    logic           accept;
    logic           keep;
    logic [1:0]     relay_idx;

    assign s_axis_tready = !r_valid || i_take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A select of a relay outside the table is accepted and dropped here.
    assign keep = (s_axis_tuser == mcfg_pkg::OP_ALL_ON) ||
                  ((s_axis_tdata >= mcfg_pkg::RELAY_FIRST) &&
                   (s_axis_tdata <= mcfg_pkg::RELAY_LAST));
    assign relay_idx = 2'(s_axis_tdata - mcfg_pkg::RELAY_FIRST);

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (accept && keep) begin
            n_valid       = 1'b1;
            n_cmd.all_on  = (s_axis_tuser == mcfg_pkg::OP_ALL_ON);
            n_cmd.target  = i_relay_map[relay_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// File: rtl/core/mcfg_frame.sv
module mcfg_frame #(
    parameter int COIL_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcfg_pkg::t_frame_cfg  i_cfg,
    input  logic                  i_cmd_valid,
    input  mcfg_pkg::t_cmd        i_cmd,
    output logic                  o_take,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // [7:0] frame_byte
    output logic                  m_axis_tuser,  // [0] frame_end
    output logic                  m_axis_tlast
);

    localparam int KW = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(COIL_COUNT - 1);

    logic                r_busy;
    logic                n_busy;
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       n_k;
    mcfg_pkg::t_byte_pos r_pos;
    mcfg_pkg::t_byte_pos n_pos;
    logic [15:0]         r_crc;
    logic [15:0]         n_crc;
    mcfg_pkg::t_cmd      r_cmd;
    mcfg_pkg::t_cmd      n_cmd;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [7:0]          r_out_byte;
    logic [7:0]          n_out_byte;
    logic                r_out_end;
    logic                n_out_end;
    logic                r_out_last;
    logic                n_out_last;

    logic                adv;
    logic                emit;
    logic                last_byte;
    logic                coil_on;
    logic [15:0]         coil_addr;
    logic [7:0]          cur_byte;
    logic [15:0]         crc_seed;

    assign adv       = !r_out_valid || m_axis_tready;
    assign emit      = r_busy && adv;
    assign last_byte = (r_pos == mcfg_pkg::POS_CRC_HI) && (r_k == K_LAST);
    assign o_take    = i_cmd_valid && (!r_busy || (emit && last_byte));

    // A mapped index at or beyond the coil count never matches, so all stay off.
    assign coil_on   = r_cmd.all_on ||
                       ({2'b00, r_k} == {{KW{1'b0}}, r_cmd.target});
    assign coil_addr = 16'(i_cfg.first_coil + 16'(r_k));

    always_comb begin
        unique case (r_pos)
            mcfg_pkg::POS_ADDR:     cur_byte = i_cfg.dev_addr;
            mcfg_pkg::POS_FUNC:     cur_byte = mcfg_pkg::FUNC_WRITE_COIL;
            mcfg_pkg::POS_COIL_HI:  cur_byte = coil_addr[15:8];
            mcfg_pkg::POS_COIL_LO:  cur_byte = coil_addr[7:0];
            mcfg_pkg::POS_VALUE_HI: cur_byte = coil_on ? mcfg_pkg::COIL_ON_BYTE
                                                       : mcfg_pkg::COIL_OFF_BYTE;
            mcfg_pkg::POS_VALUE_LO: cur_byte = mcfg_pkg::ZERO_BYTE;
            mcfg_pkg::POS_CRC_LO:   cur_byte = r_crc[7:0];
            mcfg_pkg::POS_CRC_HI:   cur_byte = r_crc[15:8];
            default:                cur_byte = mcfg_pkg::ZERO_BYTE;
        endcase
    end

    assign crc_seed = (r_pos == mcfg_pkg::POS_ADDR) ? mcfg_pkg::CRC_INIT : r_crc;

    always_comb begin
        n_busy      = r_busy;
        n_k         = r_k;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        n_out_last  = r_out_last;

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_end   = (r_pos == mcfg_pkg::POS_CRC_HI);
            n_out_last  = last_byte;
            // The checksum runs over the first six bytes as they go out.
            if (r_pos != mcfg_pkg::POS_CRC_LO && r_pos != mcfg_pkg::POS_CRC_HI) begin
                n_crc = mcfg_pkg::crc_byte(crc_seed, cur_byte);
            end
            n_pos = mcfg_pkg::t_byte_pos'(3'(r_pos + 3'd1));
            if (r_pos == mcfg_pkg::POS_CRC_HI) begin
                n_k = KW'(r_k + 1'b1);
            end
            if (last_byte) begin
                n_busy = 1'b0;
            end
        end

        if (o_take) begin
            n_busy = 1'b1;
            n_k    = '0;
            n_pos  = mcfg_pkg::POS_ADDR;
            n_cmd  = i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_pos       <= mcfg_pkg::POS_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_crc      <= n_crc;
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_end;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/core/mcfg_checker.sv
`include "modbus_coil_frame_generator_assert.svh"

module mcfg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic       out_stall;
    logic       out_last;
    logic       in_stall;
    logic [9:0] out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_last  = m_axis_tvalid && m_axis_tlast;
    assign in_stall  = s_axis_tvalid && !s_axis_tready;
    assign out_word  = {m_axis_tdata, m_axis_tuser, m_axis_tlast};

    // A stalled output word keeps its contents.
    `MCFG_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled word changed")

    // The final byte of a command always closes a frame.
    `MCFG_ASSERT(a_last_ends_frame, out_last |-> m_axis_tuser, "last byte without frame end")

    // The input side only stalls while a frame is going out or about to start.
    `MCFG_ASSERT(a_stall_busy, in_stall |-> ##[0:1] m_axis_tvalid, "input stall without output")

    // Nothing is offered right after reset.
    `MCFG_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind modbus_coil_frame_generator mcfg_checker u_checker (.*);
